// ===== sv/stt_pkg.sv =====
// Shared types, codes and field widths of the source text tokenizer.
package stt_pkg;

  // Widths of the transferred record fields.
  localparam int CHAR_W       = 8;
  localparam int OFF_FIELD_W  = 32;
  localparam int LINE_FIELD_W = 24;
  localparam int LEN_FIELD_W  = 16;

  // Default widths of the internal counters.
  localparam int OFFSET_BITS_DEF = 32;
  localparam int LINE_BITS_DEF   = 24;
  localparam int LENGTH_BITS_DEF = 16;

  // Result queue depth; it must hold two records beyond one in flight.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    K_INT    = 4'd0,
    K_ID     = 4'd1,
    K_STR    = 4'd2,
    K_SEMI   = 4'd3,
    K_LPAREN = 4'd4,
    K_RPAREN = 4'd5,
    K_LBRACE = 4'd6,
    K_RBRACE = 4'd7,
    K_ASSIGN = 4'd8,
    K_BINOP  = 4'd9,
    K_COMMA  = 4'd10,
    K_COLON  = 4'd11,
    K_PERIOD = 4'd12,
    K_ARROW  = 4'd13,
    K_EOF    = 4'd14,
    K_ERROR  = 4'd15
  } tok_kind_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_CMP   = 3'd1,
    OP_PLUS  = 3'd2,
    OP_MUL   = 3'd3,
    OP_MINUS = 3'd4,
    OP_DIV   = 3'd5
  } op_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_text;
  } stt_in_t;

  typedef struct packed {
    tok_kind_t               token_kind;
    op_kind_t                operator_kind;
    logic [LINE_FIELD_W-1:0] line_number;
    logic [OFF_FIELD_W-1:0]  start_offset;
    logic [LEN_FIELD_W-1:0]  text_length;
    logic [CHAR_W-1:0]       bad_char;
    logic                    last_of_run;
  } stt_out_t;

  // Queue write enables for the records made by one item.
  typedef struct packed {
    logic first;
    logic second;
  } stt_push_t;

endpackage

// ===== sv/stt_scan.sv =====
// Scanner: mode and counter registers plus the per-byte token logic.
module stt_scan #(
  parameter int OFFSET_BITS = 32,
  parameter int LINE_BITS   = 24,
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  stt_pkg::stt_in_t   item,
  output stt_pkg::stt_push_t push,
  output stt_pkg::stt_out_t  res0,
  output stt_pkg::stt_out_t  res1
);
  import stt_pkg::*;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_INT     = 8'b0000_0010,
    M_ID      = 8'b0000_0100,
    M_STR     = 8'b0000_1000,
    M_EQ      = 8'b0001_0000,
    M_MINUS   = 8'b0010_0000,
    M_SLASH   = 8'b0100_0000,
    M_COMMENT = 8'b1000_0000
  } mode_t;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LBRC  = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRC  = 8'h7D;

  localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_TWO  = LENGTH_BITS'(2);
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

  function automatic logic is_digit(logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [CHAR_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_blank(logic [CHAR_W-1:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
  endfunction

  function automatic stt_out_t mk_rec(tok_kind_t k, op_kind_t o,
                                      logic [LINE_BITS-1:0] ln,
                                      logic [OFFSET_BITS-1:0] s,
                                      logic [LENGTH_BITS-1:0] l,
                                      logic [CHAR_W-1:0] bad);
    stt_out_t r;
    r.token_kind    = k;
    r.operator_kind = o;
    r.line_number   = LINE_FIELD_W'(ln);
    r.start_offset  = OFF_FIELD_W'(s);
    r.text_length   = LEN_FIELD_W'(l);
    r.bad_char      = bad;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;

  logic [CHAR_W-1:0]      c;
  logic                   eot;
  logic [LINE_BITS-1:0]   line_sat;
  logic [LENGTH_BITS-1:0] len_sat;
  logic                   fl_v;
  stt_out_t               fl_rec;
  logic                   a_v, b_v, used;
  stt_out_t               a_rec, b_rec;

  assign c        = item.char_code;
  assign eot      = item.end_of_text || (c == CH_NUL);
  assign line_sat = (line_r == '1) ? line_r : line_r + LINE_ONE;
  assign len_sat  = (len_r == '1) ? len_r : len_r + LEN_ONE;

  // Record for whatever token the current mode holds.
  always_comb begin
    fl_v   = 1'b1;
    fl_rec = mk_rec(K_INT, OP_NONE, line_r, start_r, len_r, '0);
    case (mode_r)
      M_INT:   fl_rec = mk_rec(K_INT, OP_NONE, line_r, start_r, len_r, '0);
      M_ID:    fl_rec = mk_rec(K_ID, OP_NONE, line_r, start_r, len_r, '0);
      M_STR:   fl_rec = mk_rec(K_STR, OP_NONE, line_r, start_r, len_r, '0);
      M_EQ:    fl_rec = mk_rec(K_ASSIGN, OP_NONE, line_r, start_r, LEN_ONE, '0);
      M_MINUS: fl_rec = mk_rec(K_BINOP, OP_MINUS, line_r, start_r, LEN_ONE, '0);
      M_SLASH: fl_rec = mk_rec(K_BINOP, OP_DIV, line_r, start_r, LEN_ONE, '0);
      default: fl_v = 1'b0;
    endcase
  end

  // One byte step: the pending token is finished or extended first, then a
  // byte that it did not take may open a new token.
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    a_v       = 1'b0;
    a_rec     = fl_rec;
    b_v       = 1'b0;
    b_rec     = mk_rec(K_EOF, OP_NONE, line_r, pos_r, LEN_ZERO, '0);
    used      = 1'b0;
    if (eot) begin
      // A comment simply ends; any other pending token is flushed.
      a_v       = fl_v && (mode_r != M_COMMENT);
      b_v       = 1'b1;
      mode_nxt  = M_IDLE;
      pos_nxt   = '0;
      line_nxt  = LINE_ONE;
      start_nxt = '0;
      len_nxt   = '0;
    end else begin
      case (mode_r)
        M_INT: begin
          if (is_digit(c)) begin
            len_nxt = len_sat;
            used    = 1'b1;
          end else begin
            a_v = 1'b1;
          end
        end
        M_ID: begin
          if (is_digit(c) || is_alpha(c)) begin
            len_nxt = len_sat;
            used    = 1'b1;
          end else begin
            a_v = 1'b1;
          end
        end
        M_STR: begin
          used = 1'b1;
          if (c == CH_QUOTE) begin
            a_v      = 1'b1;
            mode_nxt = M_IDLE;
          end else if (c == CH_LF) begin
            a_v      = 1'b1;
            mode_nxt = M_IDLE;
            line_nxt = line_sat;
          end else begin
            len_nxt = len_sat;
          end
        end
        M_EQ: begin
          if (c == CH_EQ) begin
            a_v      = 1'b1;
            a_rec    = mk_rec(K_BINOP, OP_CMP, line_r, start_r, LEN_TWO, '0);
            mode_nxt = M_IDLE;
            used     = 1'b1;
          end else begin
            a_v = 1'b1;
          end
        end
        M_MINUS: begin
          if (c == CH_GT) begin
            a_v      = 1'b1;
            a_rec    = mk_rec(K_ARROW, OP_NONE, line_r, start_r, LEN_TWO, '0);
            mode_nxt = M_IDLE;
            used     = 1'b1;
          end else begin
            a_v = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = M_COMMENT;
            used     = 1'b1;
          end else begin
            a_v = 1'b1;
          end
        end
        M_COMMENT: begin
          used = 1'b1;
          if (c == CH_LF) begin
            line_nxt = line_sat;
            mode_nxt = M_IDLE;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
        end
      endcase

      // A byte that the pending token did not take starts from idle.
      if (!used) begin
        mode_nxt = M_IDLE;
        if (c == CH_LF) begin
          line_nxt = line_sat;
        end else if (!is_blank(c)) begin
          start_nxt = pos_r;
          len_nxt   = LEN_ONE;
          b_rec     = mk_rec(K_ERROR, OP_NONE, line_r, pos_r, LEN_ONE, c);
          if (is_digit(c)) begin
            mode_nxt = M_INT;
          end else if (is_alpha(c)) begin
            mode_nxt = M_ID;
          end else begin
            case (c)
              CH_QUOTE: begin
                mode_nxt  = M_STR;
                start_nxt = pos_r + OFFSET_BITS'(1);
                len_nxt   = LEN_ZERO;
              end
              CH_EQ:    mode_nxt = M_EQ;
              CH_DASH:  mode_nxt = M_MINUS;
              CH_SLASH: mode_nxt = M_SLASH;
              CH_SEMI: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_SEMI, OP_NONE, line_r, pos_r, LEN_ONE, '0);
              end
              CH_LPAR: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_LPAREN, OP_NONE, line_r, pos_r, LEN_ONE, '0);
              end
              CH_RPAR: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_RPAREN, OP_NONE, line_r, pos_r, LEN_ONE, '0);
              end
              CH_LBRC: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_LBRACE, OP_NONE, line_r, pos_r, LEN_ONE, '0);
              end
              CH_RBRC: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_RBRACE, OP_NONE, line_r, pos_r, LEN_ONE, '0);
              end
              CH_COMMA: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_COMMA, OP_NONE, line_r, pos_r, LEN_ONE, '0);
              end
              CH_COLON: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_COLON, OP_NONE, line_r, pos_r, LEN_ONE, '0);
              end
              CH_DOT: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_PERIOD, OP_NONE, line_r, pos_r, LEN_ONE, '0);
              end
              CH_PLUS: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_BINOP, OP_PLUS, line_r, pos_r, LEN_ONE, '0);
              end
              CH_STAR: begin
                b_v   = 1'b1;
                b_rec = mk_rec(K_BINOP, OP_MUL, line_r, pos_r, LEN_ONE, '0);
              end
              default: begin
                // Unknown byte: error token carrying the byte.
                b_v = 1'b1;
              end
            endcase
          end
        end
      end
      pos_nxt = pos_r + OFFSET_BITS'(1);
    end
  end

  // Compact the two possible records into queue order.
  always_comb begin
    push.first  = go && (a_v || b_v);
    push.second = go && a_v && b_v;
    res0        = a_v ? a_rec : b_rec;
    res0.last_of_run = !(a_v && b_v);
    res1        = b_rec;
    res1.last_of_run = 1'b1;
  end

  // Scanner state advances once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      line_r  <= LINE_ONE;
      start_r <= '0;
      len_r   <= '0;
    end else if (go) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

// ===== sv/stt_outq.sv =====
// Result queue: takes up to two records a cycle and hands out one a cycle while out_stall is low.
module stt_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  stt_pkg::stt_push_t push,
  input  stt_pkg::stt_out_t  res0,
  input  stt_pkg::stt_out_t  res1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output stt_pkg::stt_out_t  out_data
);
  import stt_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  stt_out_t      mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic [1:0]    push_n;
  logic          pop;

  assign push_n    = push.second ? 2'd2 : (push.first ? 2'd1 : 2'd0);
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rp_r];
  // Space for the two records that one item may produce.
  assign room      = (cnt_r <= CW'(QUEUE_DEPTH - 2));

  // Record storage.
  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wp_r] <= res0;
    end
    if (push.second) begin
      mem_r[wp_r + AW'(1)] <= res1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(push_n);
      rp_r  <= rp_r + AW'(pop);
      cnt_r <= cnt_r + CW'(push_n) - CW'(pop);
    end
  end

endmodule

// ===== sv/source_text_tokenizer_unit.sv =====
// Source text tokenizer: one source byte per transfer in, token records out.
//
// Input channel (in_valid, in_stall, in_data): one byte per transfer, or an
// end-of-text marker. A NUL byte acts as end of text. Output channel
// (out_valid, out_stall, out_data): token records in source order; each
// byte gives zero, one or two records and last_of_run marks the final one.
// An input transfer lands in an input register; from there the scanner
// updates its mode and counters and writes the records into a four-entry
// result queue, whose head drives out_data.
// Throughput is one byte per cycle while the input does not stall. The queue
// hands out one record per cycle while out_stall is low, and the input
// stalls while the queue holds more than two records.
// When the receiver stalls, records wait in the queue and the input stalls
// once the queue is nearly full; nothing is dropped.
// Reset (rst_n low, synchronous) empties the queue and the input register
// and returns the scanner to idle at position 0, line 1. End of text does
// the same to the scanner after its EOF record.
module source_text_tokenizer_unit #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stt_pkg::stt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stt_pkg::stt_out_t out_data
);
  import stt_pkg::*;

  logic      in_valid_r;
  stt_in_t   in_data_r;
  logic      room;
  logic      go;
  stt_push_t push;
  stt_out_t  res0, res1;

  assign go       = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  // Input register: reloads whenever the held byte is processed or empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  stt_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_data_r),
    .push  (push),
    .res0  (res0),
    .res1  (res1)
  );

  stt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/stt_checker.sv =====
// Port-level checks of the tokenizer and their attachment to the top level.
module stt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input stt_pkg::stt_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input stt_pkg::stt_out_t out_data
);
  import stt_pkg::*;

  // A stalled record stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result transfer was withdrawn");

  // A stalled record keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result payload changed");

  // With nothing waiting at the output, the input cannot stall next cycle.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |=> !in_stall)
    else $error("input stalled although the result queue had drained");

  // EOF is always the final record of its byte.
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == K_EOF) |-> out_data.last_of_run)
    else $error("EOF record not marked last of run");

  // Only binary operators carry an operator subtype.
  a_op_only_binop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind != K_BINOP) |->
      (out_data.operator_kind == OP_NONE))
    else $error("operator subtype on a non-operator token");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (.*);

// ===== tb/tb_source_text_tokenizer_unit.sv =====
// Self-checking testbench for the source text tokenizer with a built-in token predictor.
module tb_source_text_tokenizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  // Character codes the scanner treats specially.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_EQ     = "=";
  localparam logic [7:0] CH_GT     = ">";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_COLON  = ":";
  localparam logic [7:0] CH_PERIOD = ".";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_STAR   = "*";

  localparam int RANDOM_BYTES = 1040;
  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_CYCLES = 20;

  typedef enum {
    SCAN_IDLE, SCAN_INT, SCAN_IDENT, SCAN_STRING,
    SCAN_EQUAL, SCAN_MINUS, SCAN_SLASH, SCAN_COMMENT
  } scan_state_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  stt_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  stt_out_t  out_data;

  // Scanner state as the predictor sees it.
  scan_state_t                 scan;
  logic [OFFSET_BITS_DEF-1:0] src_pos;
  logic [LINE_BITS_DEF-1:0]   line_cnt;
  logic [OFFSET_BITS_DEF-1:0] tok_start;
  logic [LENGTH_BITS_DEF-1:0] tok_len;

  stt_in_t  source_bytes[$];
  stt_out_t pending_tokens[$];
  stt_out_t run_tokens[$];
  stt_out_t want_token;

  int  bytes_total;
  int  bytes_accepted = 0;
  int  failures = 0;
  int  idle_cycles = 0;
  int  in_wait = 0;
  int  hold_left = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  string punct_set = ";(){},:.+*";
  string odd_set   = "_#@$?!%&^~'|[]<>";

  source_text_tokenizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic void clear_scanner();
    scan      = SCAN_IDLE;
    src_pos   = '0;
    line_cnt  = LINE_BITS_DEF'(1);
    tok_start = '0;
    tok_len   = '0;
  endfunction

  function automatic void line_up();
    if (line_cnt != '1) line_cnt++;
  endfunction

  function automatic void bump_len();
    if (tok_len != '1) tok_len++;
  endfunction

  function automatic void add_token(tok_kind_t kind, op_kind_t op,
                                    logic [OFF_FIELD_W-1:0] start,
                                    logic [LEN_FIELD_W-1:0] len, logic [7:0] bad);
    stt_out_t t;
    t.token_kind    = kind;
    t.operator_kind = op;
    t.line_number   = line_cnt;
    t.start_offset  = start;
    t.text_length   = len;
    t.bad_char      = bad;
    t.last_of_run   = 1'b0;
    run_tokens.push_back(t);
  endfunction

  // Emit the token that the current scan state holds and return to idle.
  function automatic void emit_pending();
    case (scan)
      SCAN_INT:    add_token(K_INT, OP_NONE, tok_start, tok_len, 8'h00);
      SCAN_IDENT:  add_token(K_ID, OP_NONE, tok_start, tok_len, 8'h00);
      SCAN_STRING: add_token(K_STR, OP_NONE, tok_start, tok_len, 8'h00);
      SCAN_EQUAL:  add_token(K_ASSIGN, OP_NONE, tok_start, 16'd1, 8'h00);
      SCAN_MINUS:  add_token(K_BINOP, OP_MINUS, tok_start, 16'd1, 8'h00);
      SCAN_SLASH:  add_token(K_BINOP, OP_DIV, tok_start, 16'd1, 8'h00);
      default: ;
    endcase
    scan = SCAN_IDLE;
  endfunction

  // Work out the token records caused by one accepted byte.
  function automatic void tokenize_byte(stt_in_t item);
    logic [7:0] c;
    bit         consumed;
    stt_out_t   tail;
    c = item.char_code;
    consumed = 1'b0;
    run_tokens.delete();
    if (item.end_of_text || c == CH_NUL) begin
      // A comment at end of text simply ends; anything else is flushed.
      if (scan != SCAN_COMMENT) emit_pending();
      add_token(K_EOF, OP_NONE, src_pos, 16'd0, 8'h00);
      clear_scanner();
    end else begin
      case (scan)
        SCAN_INT: begin
          if (is_digit(c)) begin
            bump_len();
            consumed = 1'b1;
          end else emit_pending();
        end
        SCAN_IDENT: begin
          if (is_digit(c) || is_alpha(c)) begin
            bump_len();
            consumed = 1'b1;
          end else emit_pending();
        end
        SCAN_STRING: begin
          // A newline closes the string and is still counted as a line.
          consumed = 1'b1;
          if (c == CH_QUOTE) emit_pending();
          else if (c == CH_NL) begin
            emit_pending();
            line_up();
          end else bump_len();
        end
        SCAN_EQUAL: begin
          if (c == CH_EQ) begin
            add_token(K_BINOP, OP_CMP, tok_start, 16'd2, 8'h00);
            scan = SCAN_IDLE;
            consumed = 1'b1;
          end else emit_pending();
        end
        SCAN_MINUS: begin
          if (c == CH_GT) begin
            add_token(K_ARROW, OP_NONE, tok_start, 16'd2, 8'h00);
            scan = SCAN_IDLE;
            consumed = 1'b1;
          end else emit_pending();
        end
        SCAN_SLASH: begin
          if (c == CH_SLASH) begin
            scan = SCAN_COMMENT;
            consumed = 1'b1;
          end else emit_pending();
        end
        SCAN_COMMENT: begin
          consumed = 1'b1;
          if (c == CH_NL) begin
            line_up();
            scan = SCAN_IDLE;
          end
        end
        default: scan = SCAN_IDLE;
      endcase

      // A byte not absorbed by the token in progress starts a new one, unless it is blank or a newline.
      if (!consumed && !is_blank(c)) begin
        if (c == CH_NL) line_up();
        else begin
          tok_start = src_pos;
          tok_len   = LENGTH_BITS_DEF'(1);
          if (is_digit(c)) scan = SCAN_INT;
          else if (is_alpha(c)) scan = SCAN_IDENT;
          else begin
            case (c)
              CH_QUOTE: begin
                scan      = SCAN_STRING;
                tok_start = src_pos + OFFSET_BITS_DEF'(1);
                tok_len   = '0;
              end
              CH_EQ:     scan = SCAN_EQUAL;
              CH_MINUS:  scan = SCAN_MINUS;
              CH_SLASH:  scan = SCAN_SLASH;
              CH_SEMI:   add_token(K_SEMI, OP_NONE, src_pos, 16'd1, 8'h00);
              CH_LPAREN: add_token(K_LPAREN, OP_NONE, src_pos, 16'd1, 8'h00);
              CH_RPAREN: add_token(K_RPAREN, OP_NONE, src_pos, 16'd1, 8'h00);
              CH_LBRACE: add_token(K_LBRACE, OP_NONE, src_pos, 16'd1, 8'h00);
              CH_RBRACE: add_token(K_RBRACE, OP_NONE, src_pos, 16'd1, 8'h00);
              CH_COMMA:  add_token(K_COMMA, OP_NONE, src_pos, 16'd1, 8'h00);
              CH_COLON:  add_token(K_COLON, OP_NONE, src_pos, 16'd1, 8'h00);
              CH_PERIOD: add_token(K_PERIOD, OP_NONE, src_pos, 16'd1, 8'h00);
              CH_PLUS:   add_token(K_BINOP, OP_PLUS, src_pos, 16'd1, 8'h00);
              CH_STAR:   add_token(K_BINOP, OP_MUL, src_pos, 16'd1, 8'h00);
              default:   add_token(K_ERROR, OP_NONE, src_pos, 16'd1, c);
            endcase
          end
        end
      end
      src_pos = src_pos + OFFSET_BITS_DEF'(1);
    end

    // Mark the final record of this byte and queue them all.
    if (run_tokens.size() > 0) begin
      tail = run_tokens.pop_back();
      tail.last_of_run = 1'b1;
      run_tokens.push_back(tail);
    end
    foreach (run_tokens[i]) pending_tokens.push_back(run_tokens[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_byte(logic [7:0] c);
    source_bytes.push_back(stt_in_t'{char_code: c, end_of_text: 1'b0});
  endfunction

  function automatic void push_eot(logic [7:0] c);
    source_bytes.push_back(stt_in_t'{char_code: c, end_of_text: 1'b1});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed tokens with random content, plus some raw noise.
  function automatic void queue_random_token();
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      push_byte(rand_letter());
      n = $urandom_range(0, 5);
      repeat (n) push_byte($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
    end else if (pick < 27) begin
      n = $urandom_range(1, 5);
      repeat (n) push_byte(rand_digit());
    end else if (pick < 35) begin
      push_byte(CH_QUOTE);
      n = $urandom_range(0, 5);
      repeat (n) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_NL);
        push_byte(c);
      end
      if ($urandom_range(0, 6) != 0) push_byte(CH_QUOTE);
      else push_byte(CH_NL);
    end else if (pick < 55) begin
      push_byte(punct_set[$urandom_range(0, punct_set.len() - 1)]);
    end else if (pick < 60) begin
      push_text("==");
    end else if (pick < 65) begin
      push_byte(CH_EQ);
    end else if (pick < 70) begin
      push_text("->");
    end else if (pick < 74) begin
      push_byte(CH_MINUS);
    end else if (pick < 78) begin
      push_byte(CH_SLASH);
    end else if (pick < 82) begin
      push_text("//");
      n = $urandom_range(0, 6);
      repeat (n) begin
        do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
        push_byte(c);
      end
      if ($urandom_range(0, 9) != 0) push_byte(CH_NL);
    end else if (pick < 86) begin
      push_byte(CH_NL);
    end else if (pick < 90) begin
      case ($urandom_range(0, 2))
        0: push_byte(odd_set[$urandom_range(0, odd_set.len() - 1)]);
        1: push_byte(8'($urandom_range(128, 255)));
        default: push_byte(8'($urandom_range(1, 8)));
      endcase
    end else if (pick < 95) begin
      case ($urandom_range(0, 4))
        0: push_byte(CH_SPACE);
        1: push_byte(CH_TAB);
        2: push_byte(CH_VT);
        3: push_byte(CH_FF);
        default: push_byte(CH_CR);
      endcase
    end else if (pick < 98) begin
      push_byte(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 1)) push_eot(8'($urandom_range(0, 255)));
      else push_byte(CH_NUL);
    end
    if ($urandom_range(0, 9) < 6) push_byte(CH_SPACE);
  endfunction

  // ---------------------------------------------------------------- driver

  // Offer the next byte after a transfer, with a random gap before each one.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (source_bytes.size() > 0) begin
        in_data  <= source_bytes.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
        in_wait = in_calm ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel for a random number of cycles after each transfer.
  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      hold_left = out_calm ? 0 : $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // Check each result transfer, predict each input transfer, and watch for a hang.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken    <= 1'b0;
      out_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken  <= in_valid && !in_stall;
      out_taken <= out_valid && !out_stall;

      if (out_valid && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          $error("token record with none expected: kind %0d", out_data.token_kind);
          failures++;
        end else begin
          want_token = pending_tokens.pop_front();
          check_field("token_kind", 32'(want_token.token_kind),
                      32'(out_data.token_kind));
          check_field("operator_kind", 32'(want_token.operator_kind),
                      32'(out_data.operator_kind));
          check_field("line_number", 32'(want_token.line_number),
                      32'(out_data.line_number));
          check_field("start_offset", want_token.start_offset, out_data.start_offset);
          check_field("text_length", 32'(want_token.text_length),
                      32'(out_data.text_length));
          check_field("bad_char", 32'(want_token.bad_char), 32'(out_data.bad_char));
          check_field("last_of_run", 32'(want_token.last_of_run),
                      32'(out_data.last_of_run));
        end
      end

      if (in_valid && !in_stall) begin
        tokenize_byte(in_data);
        bytes_accepted++;
      end

      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_scanner();

    // Directed: every operator pair, comment, newline-ended string, unknown bytes,
    // a pending string and a comment at end of text, and NUL as end of text.
    push_text("ab1==7->x-3/y//c\n\"s\n");
    push_byte(8'hFF);
    push_byte("_");
    push_eot(8'hFF);
    push_text("\"t");
    push_eot(CH_NUL);
    push_text("=//");
    push_byte(CH_NUL);

    // Random token streams.
    while (source_bytes.size() < RANDOM_BYTES) queue_random_token();
    push_eot(CH_NUL);

    bytes_total = source_bytes.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (bytes_accepted != bytes_total || pending_tokens.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
